// ----- hw/rtl/rmrs_pkg.sv -----
`timescale 1ns / 1ps
// Shared constants, codes and controller/datapath interface types.
package rmrs_pkg;

   localparam int SLOTS        = 32;
   localparam int SLOT_W       = (SLOTS > 1) ? $clog2(SLOTS) : 1;
   localparam int SECTOR_BYTES = 512;
   localparam int SECTOR_SHIFT = $clog2(SECTOR_BYTES);

   localparam int REQ_W      = 2;
   localparam int ADDR_W     = 48;
   localparam int LEN_W      = 32;
   localparam int LBA_W      = 45;
   localparam int CNT_W      = 40;
   localparam int STATUS_W   = 3;
   localparam int SLOT_OUT_W = 5;

   // End sector is kept exact, one bit wider than the wrapping allocator.
   localparam int END_W   = LBA_W + 1;
   // Byte position wide enough to reach the end of any region.
   localparam int POS_W   = END_W + SECTOR_SHIFT;
   localparam int ROUND_W = ADDR_W + 1;

   typedef enum logic [STATUS_W-1:0] {
      STS_OK          = 3'd0,
      STS_ZERO_LENGTH = 3'd1,
      STS_UNMAPPED    = 3'd2,
      STS_READ_ONLY   = 3'd3,
      STS_TABLE_FULL  = 3'd4
   } status_type;

   typedef enum logic [REQ_W-1:0] {
      REQ_MAP   = 2'd0,
      REQ_READ  = 2'd1,
      REQ_WRITE = 2'd2
   } req_code_type;

   typedef enum logic [2:0] {
      EMIT_MAP,
      EMIT_ZERO,
      EMIT_UNMAPPED,
      EMIT_READ_ONLY,
      EMIT_CHUNK
   } emit_kind_type;

   typedef struct packed {
      logic          load;
      logic          scan_start;
      logic          scan_run;
      logic          calc_avail;
      logic          emit;
      emit_kind_type kind;
   } cmd_type;

   typedef struct packed {
      logic [REQ_W-1:0] req_code;
      logic             rem_zero;
      logic             out_free;
      logic             hit;
      logic             miss_end;
      logic             hit_writable;
      logic             last_chunk;
   } sts_type;

   typedef struct packed {
      logic             writable;
      logic [LBA_W-1:0] base;
      logic [END_W-1:0] end_sec;
   } slot_entry_type;

endpackage

// ----- hw/rtl/rmrs_ctrl.sv -----
`timescale 1ns / 1ps
// Request sequencer: decodes an item and steps the datapath through map, scan and chunk emit.
module rmrs_ctrl import rmrs_pkg::*; (
   input  logic    clock,
   input  logic    reset,
   input  logic    req_valid,
   output logic    req_stall,
   input  sts_type sts,
   output cmd_type cmd
);

   typedef enum logic [3:0] {
      S_IDLE,
      S_DECODE,
      S_MAP,
      S_ZERO,
      S_SCAN,
      S_AVAIL,
      S_CHUNK,
      S_UNMAPPED,
      S_READ_ONLY
   } state_type;

   state_type state_ff;
   state_type state_in;

   always_comb begin
      state_in = state_ff;
      cmd      = '0;
      cmd.kind = EMIT_CHUNK;
      case (state_ff)
         S_IDLE: begin
            if (req_valid) begin
               cmd.load = 1'b1;
               state_in = S_DECODE;
            end
         end
         S_DECODE: begin
            case (sts.req_code)
               REQ_MAP: state_in = S_MAP;
               REQ_READ, REQ_WRITE: begin
                  if (sts.rem_zero) begin
                     state_in = S_ZERO;
                  end else begin
                     cmd.scan_start = 1'b1;
                     state_in       = S_SCAN;
                  end
               end
               // unknown request: drop it
               default: state_in = S_IDLE;
            endcase
         end
         S_MAP: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = EMIT_MAP;
               state_in = S_IDLE;
            end
         end
         S_ZERO: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = EMIT_ZERO;
               state_in = S_IDLE;
            end
         end
         S_SCAN: begin
            cmd.scan_run = 1'b1;
            if (sts.hit) begin
               if ((sts.req_code == REQ_WRITE) && !sts.hit_writable) begin
                  state_in = S_READ_ONLY;
               end else begin
                  state_in = S_AVAIL;
               end
            end else if (sts.miss_end) begin
               state_in = S_UNMAPPED;
            end
         end
         S_AVAIL: begin
            cmd.calc_avail = 1'b1;
            state_in       = S_CHUNK;
         end
         S_CHUNK: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = EMIT_CHUNK;
               if (sts.last_chunk) begin
                  state_in = S_IDLE;
               end else begin
                  // advance to the next region
                  cmd.scan_start = 1'b1;
                  state_in       = S_SCAN;
               end
            end
         end
         S_UNMAPPED: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = EMIT_UNMAPPED;
               state_in = S_IDLE;
            end
         end
         S_READ_ONLY: begin
            if (sts.out_free) begin
               cmd.emit = 1'b1;
               cmd.kind = EMIT_READ_ONLY;
               state_in = S_IDLE;
            end
         end
         default: state_in = S_IDLE;
      endcase
   end

   assign req_stall = (state_ff != S_IDLE);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
      end else begin
         state_ff <= state_in;
      end
   end

`ifndef SYNTHESIS
   a_emit_needs_room: assert property (@(posedge clock) disable iff (reset)
      cmd.emit |-> sts.out_free)
      else $error("result loaded while output register is occupied");

   a_scan_exclusive: assert property (@(posedge clock) disable iff (reset)
      !(cmd.scan_start && cmd.scan_run))
      else $error("scan restarted while running");

   a_hit_leaves_scan: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && sts.hit) |=>
         (state_ff == S_AVAIL || state_ff == S_READ_ONLY))
      else $error("region hit did not end the scan");

   a_miss_reports: assert property (@(posedge clock) disable iff (reset)
      (state_ff == S_SCAN && sts.miss_end) |=> (state_ff == S_UNMAPPED))
      else $error("scan ran off the table without reporting unmapped");
`endif

endmodule

// ----- hw/rtl/rmrs_datapath.sv -----
`timescale 1ns / 1ps
// Region table, slot allocator, scan pipeline, chunk arithmetic and result register.
module rmrs_datapath import rmrs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic [REQ_W-1:0]      req_type,
   input  logic [ADDR_W-1:0]     req_address,
   input  logic [LEN_W-1:0]      req_length,
   input  logic [ADDR_W-1:0]     req_image_bytes,
   input  logic                  req_can_write,
   input  cmd_type               cmd,
   output sts_type               sts,
   input  logic                  rsp_stall,
   output logic                  rsp_valid,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [SLOT_OUT_W-1:0] rsp_slot,
   output logic [ADDR_W-1:0]     rsp_region_offset,
   output logic [LEN_W-1:0]      rsp_chunk_len,
   output logic [LBA_W-1:0]      rsp_start_sector,
   output logic [CNT_W-1:0]      rsp_sector_count,
   output logic                  rsp_last
);

   // request registers
   logic [REQ_W-1:0] req_code_ff;
   logic [POS_W-1:0] pos_ff;
   logic [LEN_W-1:0] rem_ff;
   logic [CNT_W-1:0] cnt_ff;
   logic             can_write_ff;

   // allocator and table
   logic [LBA_W-1:0] next_base_ff;
   logic [SLOTS-1:0] used_ff;
   slot_entry_type   slot_table_ff [SLOTS];

   // scan pipeline
   logic [SLOT_W-1:0] idx_ff;
   logic [SLOT_W-1:0] rd_idx_ff;
   logic              rd_vld_ff;
   slot_entry_type    rd_word_ff;

   // captured hit
   logic [SLOT_W-1:0] hit_slot_ff;
   logic [LBA_W-1:0]  hit_base_ff;
   logic [END_W-1:0]  hit_end_ff;
   logic [LEN_W-1:0]  avail_ff;

   // result register
   logic                  rsp_valid_ff;
   status_type            rsp_status_ff;
   logic [SLOT_W-1:0]     rsp_slot_ff;
   logic [ADDR_W-1:0]     rsp_offset_ff;
   logic [LEN_W-1:0]      rsp_len_ff;
   logic [LBA_W-1:0]      rsp_base_ff;
   logic [CNT_W-1:0]      rsp_count_ff;
   logic                  rsp_last_ff;

   status_type            rsp_status_in;
   logic [SLOT_W-1:0]     rsp_slot_in;
   logic [ADDR_W-1:0]     rsp_offset_in;
   logic [LEN_W-1:0]      rsp_len_in;
   logic [LBA_W-1:0]      rsp_base_in;
   logic [CNT_W-1:0]      rsp_count_in;
   logic                  rsp_last_in;

   logic                  free_found;
   logic [SLOT_W-1:0]     free_idx;
   logic [ROUND_W-1:0]    round_sum;
   logic [POS_W-1:0]      rd_start;
   logic [POS_W-1:0]      rd_end;
   logic                  hit_now;
   logic                  miss_end;
   logic [POS_W-1:0]      avail_diff;
   logic [LEN_W-1:0]      avail_in;
   logic                  last_chunk;
   logic [LEN_W-1:0]      chunk;
   logic [POS_W-1:0]      offset_full;
   logic [END_W-1:0]      new_end;
   slot_entry_type        new_entry;
   logic                  map_commit;
   logic                  out_free;

   // lowest free slot
   always_comb begin
      free_found = 1'b0;
      free_idx   = '0;
      for (int i = SLOTS - 1; i >= 0; i--) begin
         if (!used_ff[i]) begin
            free_found = 1'b1;
            free_idx   = SLOT_W'(i);
         end
      end
   end

   assign round_sum = ROUND_W'(req_image_bytes) + ROUND_W'(SECTOR_BYTES - 1);

   assign rd_start = POS_W'({rd_word_ff.base, {SECTOR_SHIFT{1'b0}}});
   assign rd_end   = {rd_word_ff.end_sec, {SECTOR_SHIFT{1'b0}}};
   assign hit_now  = rd_vld_ff && used_ff[rd_idx_ff] && (pos_ff >= rd_start) &&
                     (pos_ff < rd_end);
   assign miss_end = rd_vld_ff && !hit_now && (rd_idx_ff == SLOT_W'(SLOTS - 1));

   assign avail_diff = {hit_end_ff, {SECTOR_SHIFT{1'b0}}} - pos_ff;
   assign avail_in   = (|avail_diff[POS_W-1:LEN_W]) ? {LEN_W{1'b1}}
                                                     : avail_diff[LEN_W-1:0];
   assign last_chunk  = (avail_ff >= rem_ff);
   assign chunk       = last_chunk ? rem_ff : avail_ff;
   assign offset_full = pos_ff - POS_W'({hit_base_ff, {SECTOR_SHIFT{1'b0}}});

   assign new_end            = END_W'(next_base_ff) + END_W'(cnt_ff);
   assign new_entry.writable = can_write_ff;
   assign new_entry.base     = next_base_ff;
   assign new_entry.end_sec  = new_end;

   assign map_commit = cmd.emit && (cmd.kind == EMIT_MAP) && free_found;
   assign out_free   = !rsp_valid_ff || !rsp_stall;

   always_comb begin
      rsp_status_in = STS_OK;
      rsp_slot_in   = '0;
      rsp_offset_in = '0;
      rsp_len_in    = '0;
      rsp_base_in   = '0;
      rsp_count_in  = '0;
      rsp_last_in   = 1'b1;
      case (cmd.kind)
         EMIT_MAP: begin
            if (free_found) begin
               rsp_slot_in  = free_idx;
               rsp_base_in  = next_base_ff;
               rsp_count_in = cnt_ff;
            end else begin
               rsp_status_in = STS_TABLE_FULL;
            end
         end
         EMIT_ZERO:     rsp_status_in = STS_ZERO_LENGTH;
         EMIT_UNMAPPED: rsp_status_in = STS_UNMAPPED;
         EMIT_READ_ONLY: begin
            rsp_status_in = STS_READ_ONLY;
            rsp_slot_in   = hit_slot_ff;
         end
         EMIT_CHUNK: begin
            rsp_slot_in   = hit_slot_ff;
            rsp_offset_in = offset_full[ADDR_W-1:0];
            rsp_len_in    = chunk;
            rsp_last_in   = last_chunk;
         end
         default: rsp_status_in = STS_OK;
      endcase
   end

   // control state
   always_ff @(posedge clock) begin
      if (reset) begin
         next_base_ff <= '0;
         used_ff      <= '0;
         idx_ff       <= '0;
         rd_idx_ff    <= '0;
         rd_vld_ff    <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         if (map_commit) begin
            used_ff[free_idx] <= 1'b1;
            next_base_ff      <= next_base_ff + LBA_W'(cnt_ff);
         end
         if (cmd.scan_start) begin
            idx_ff    <= '0;
            rd_vld_ff <= 1'b0;
         end else begin
            rd_vld_ff <= cmd.scan_run;
            if (cmd.scan_run) begin
               idx_ff    <= idx_ff + SLOT_W'(1);
               rd_idx_ff <= idx_ff;
            end
         end
         if (cmd.emit) begin
            rsp_valid_ff <= 1'b1;
         end else if (!rsp_stall) begin
            rsp_valid_ff <= 1'b0;
         end
      end
   end

   // table memory
   always_ff @(posedge clock) begin
      if (map_commit) begin
         slot_table_ff[free_idx] <= new_entry;
      end
      if (cmd.scan_run) begin
         rd_word_ff <= slot_table_ff[idx_ff];
      end
   end

   // payload registers
   always_ff @(posedge clock) begin
      if (cmd.load) begin
         req_code_ff  <= req_type;
         pos_ff       <= POS_W'(req_address);
         rem_ff       <= req_length;
         can_write_ff <= req_can_write;
         cnt_ff       <= CNT_W'(round_sum >> SECTOR_SHIFT);
      end else if (cmd.emit && (cmd.kind == EMIT_CHUNK)) begin
         rem_ff <= rem_ff - chunk;
         pos_ff <= pos_ff + POS_W'(chunk);
      end
      // hold the first matching slot of this scan
      if (cmd.scan_run && hit_now) begin
         hit_slot_ff <= rd_idx_ff;
         hit_base_ff <= rd_word_ff.base;
         hit_end_ff  <= rd_word_ff.end_sec;
      end
      if (cmd.calc_avail) begin
         avail_ff <= avail_in;
      end
      if (cmd.emit) begin
         rsp_status_ff <= rsp_status_in;
         rsp_slot_ff   <= rsp_slot_in;
         rsp_offset_ff <= rsp_offset_in;
         rsp_len_ff    <= rsp_len_in;
         rsp_base_ff   <= rsp_base_in;
         rsp_count_ff  <= rsp_count_in;
         rsp_last_ff   <= rsp_last_in;
      end
   end

   assign sts.req_code     = req_code_ff;
   assign sts.rem_zero     = (rem_ff == '0);
   assign sts.out_free     = out_free;
   assign sts.hit          = hit_now;
   assign sts.miss_end     = miss_end;
   assign sts.hit_writable = rd_word_ff.writable;
   assign sts.last_chunk   = last_chunk;

   assign rsp_valid         = rsp_valid_ff;
   assign rsp_status        = rsp_status_ff;
   assign rsp_slot          = SLOT_OUT_W'(rsp_slot_ff);
   assign rsp_region_offset = rsp_offset_ff;
   assign rsp_chunk_len     = rsp_len_ff;
   assign rsp_start_sector  = rsp_base_ff;
   assign rsp_sector_count  = rsp_count_ff;
   assign rsp_last          = rsp_last_ff;

endmodule

// ----- hw/rtl/region_map_request_splitter.sv -----
`timescale 1ns / 1ps
// Flow: a map item's result is registered after the decode and map states; an access's first
// chunk is registered after the decode, scan, avail and chunk states, s being the matched slot index.
// Throughput: one item at a time; each chunk rescans the table from slot 0 up to slot s, with the
// one-slot-per-cycle scan through the single memory read port; an unmapped stop scans every slot.
// Reset clears the slot-used bits, the allocator base and the sequencer; table entries are
// not cleared and can match only in used slots.
module region_map_request_splitter import rmrs_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  req_valid,
   output logic                  req_stall,
   input  logic [REQ_W-1:0]      req_type,
   input  logic [ADDR_W-1:0]     req_address,
   input  logic [LEN_W-1:0]      req_length,
   input  logic [ADDR_W-1:0]     req_image_bytes,
   input  logic                  req_can_write,
   output logic                  rsp_valid,
   input  logic                  rsp_stall,
   output logic [STATUS_W-1:0]   rsp_status,
   output logic [SLOT_OUT_W-1:0] rsp_slot,
   output logic [ADDR_W-1:0]     rsp_region_offset,
   output logic [LEN_W-1:0]      rsp_chunk_len,
   output logic [LBA_W-1:0]      rsp_start_sector,
   output logic [CNT_W-1:0]      rsp_sector_count,
   output logic                  rsp_last
);

   cmd_type cmd;
   sts_type sts;

   rmrs_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .req_valid (req_valid),
      .req_stall (req_stall),
      .sts       (sts),
      .cmd       (cmd)
   );

   rmrs_datapath u_datapath (
      .clock             (clock),
      .reset             (reset),
      .req_type          (req_type),
      .req_address       (req_address),
      .req_length        (req_length),
      .req_image_bytes   (req_image_bytes),
      .req_can_write     (req_can_write),
      .cmd               (cmd),
      .sts               (sts),
      .rsp_stall         (rsp_stall),
      .rsp_valid         (rsp_valid),
      .rsp_status        (rsp_status),
      .rsp_slot          (rsp_slot),
      .rsp_region_offset (rsp_region_offset),
      .rsp_chunk_len     (rsp_chunk_len),
      .rsp_start_sector  (rsp_start_sector),
      .rsp_sector_count  (rsp_sector_count),
      .rsp_last          (rsp_last)
   );

endmodule
